/* rtl/core/stil_pkg.sv */
// ----------------------------------------------------------------------------
// stil_pkg
// Shared types and codes for the sorted table: operation and status codes
// and the command that is broadcast to every storage cell.
// ----------------------------------------------------------------------------
package stil_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // operation codes (func)
  localparam logic [FuncW-1:0] OP_INSERT = 2'd0;
  localparam logic [FuncW-1:0] OP_REMOVE = 2'd1;
  localparam logic [FuncW-1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;

  // command seen by every cell in the same cycle
  typedef struct packed {
    logic                     ins;    // shift right and place value
    logic                     rem;    // shift left over the removed entry
    logic signed [ValueW-1:0] value;
  } stil_cmd_t;

endpackage

/* rtl/core/stil_cell.sv */
// ----------------------------------------------------------------------------
// stil_cell
// One slot of the sorted table. Compares its entry with the broadcast value,
// tells its right neighbor where the insert point lies, and on a write takes
// its own value, the new value, or a neighbor's entry.
// ----------------------------------------------------------------------------
module stil_cell (
  input  logic                             clk,
  input  stil_pkg::stil_cmd_t              cmd,
  input  logic                             valid,       // slot index below count
  input  logic                             left_gt,     // left slot lies past the insert point
  input  logic signed [stil_pkg::ValueW-1:0] left_entry,
  input  logic signed [stil_pkg::ValueW-1:0] right_entry,
  output logic signed [stil_pkg::ValueW-1:0] entry,
  output logic                             gt,
  output logic                             hit
);
  import stil_pkg::*;

  logic                     ge;
  logic signed [ValueW-1:0] entry_next;

  // empty slots count as "above" so an insert lands at the end of the run
  assign gt  = !valid || (entry > cmd.value);
  assign ge  = valid && (entry >= cmd.value);
  assign hit = valid && (entry == cmd.value);

  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (gt) begin
        entry_next = cmd.value;
      end
    end else if (cmd.rem) begin
      if (ge) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/core/sorted_table_insert_remove_lookup.sv */
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_lookup
// Ascending table of signed 32-bit values with insert, remove-one and
// membership query, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit first)
//  s_*      in   tuser: func[1:0]; tdata: value[31:0]
//  m_*      out  tdata: status[1:0], found[2], count[7:3]
//
//  One request per cycle while no held result stalls input: every cell compares
//  its entry with the operand in parallel and shifts by one slot in the same
//  cycle, and the result is registered on acceptance.
//  Reset clears the fill count and the output valid; entries need none.
//  A held result stalls input only while m_tready is low.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_lookup #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // status[1:0], found[2], count[7:3]
);
  import stil_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic [FuncW-1:0]         func;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            cnt_next;
  logic                     full;
  logic                     found_any;
  stil_cmd_t                cmd;
  logic signed [ValueW-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CAPACITY-1:0]      hit;
  logic [StatW-1:0]         status_next;
  logic                     found_next;
  logic [StatW-1:0]         status;
  logic                     found;

  assign func      = s_tuser;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign full      = (cnt == CW'(CAPACITY));
  assign found_any = |hit;

  assign cmd.value = s_tdata[ValueW-1:0];
  assign cmd.ins   = accept && (func == OP_INSERT) && !full;
  assign cmd.rem   = accept && (func == OP_REMOVE) && found_any;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_gt;
    logic signed [ValueW-1:0] left_entry;
    logic signed [ValueW-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = entry[0];
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_entry = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    stil_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (cnt > CW'(i)),
      .left_gt    (left_gt),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (entry[i]),
      .gt         (gt[i]),
      .hit        (hit[i])
    );
  end

  always_comb begin
    cnt_next    = cnt;
    status_next = ST_OK;
    found_next  = 1'b0;
    case (func)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (found_any) begin
          cnt_next = cnt - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        found_next = found_any;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found  <= found_next;
    end
  end

  assign m_tdata = {CountW'(cnt), found, status};

  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (func == OP_INSERT) && !full |=> cnt == $past(cnt) + CW'(1))
    else $error("insert did not grow the table");

  a_query_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (func == OP_QUERY) |=> $stable(cnt))
    else $error("query changed the fill count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_FULL) |-> cnt == CW'(CAPACITY))
    else $error("full status with room left");

endmodule
